/* design/histeq_pkg.sv */
`timescale 1ns / 1ps
package histeq_pkg;
  localparam int unsigned BINS = 256;
  localparam int unsigned BIN_W = 8;
  localparam int unsigned CNT_W = 21;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned LVL_W = 8;
  localparam int unsigned NUM_W = CNT_W + LVL_W;
  localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(1048576);
  localparam logic [LVL_W-1:0] LEVELS_RST = 8'd255;
  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_MAP = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CLR   = 9'b000000010,
    ST_CNT_R = 9'b000000100,
    ST_CNT_W = 9'b000001000,
    ST_BUILD = 9'b000010000,
    ST_MAP_R = 9'b000100000,
    ST_MAP_D = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic [NUM_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;
endpackage

/* design/histeq_ram.sv */
`timescale 1ns / 1ps
module histeq_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/histeq_div.sv */
`timescale 1ns / 1ps
module histeq_div (
  input  logic                 clk,
  input  logic                 rst,
  input  histeq_pkg::div_req_t req,
  output histeq_pkg::div_rsp_t rsp
);
  localparam int unsigned NW = histeq_pkg::NUM_W;
  localparam int unsigned DW = histeq_pkg::CNT_W;

  logic [NW-1:0] quo;
  logic [DW:0]   rem;
  logic [DW-1:0] den;
  logic [$clog2(NW+1)-1:0] cnt;
  logic busy;
  logic done;
  logic [DW:0] rem_sh;
  logic [DW:0] rem_sub;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem[DW-1:0], quo[NW-1]};
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= ($clog2(NW+1))'(NW);
        quo  <= req.num;
        den  <= req.den;
        rem  <= '0;
      end else if (busy) begin
        if (!rem_sub[DW]) begin
          rem <= rem_sub;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

  ap_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("done without busy");
  ap_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("start while busy");
  ap_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done) else $error("done held");
endmodule

/* design/histogram_equalizer_core.sv */
`timescale 1ns / 1ps
// Histogram equalizer for 8-bit grey images, two passes per frame.
// Input channel: in_valid/in_stall with func, pixel, frame_start. func=0
// counts the pixel into the 256-bin histogram (frame_start clears it first),
// func=1 maps the pixel and gives one out_pixel on out_valid/out_stall.
// Config channel: cfg_valid/cfg_ready writes levels (reset 255); write only
// while idle.
// Count item: histogram memory read, modify, write back.
// Map item: cumulative memory read, then the 29-step serial divider; the
// divide is skipped when the denominator is flat or the pixel is at or below
// cdfmin. The first map after any count also runs a cumulative build through
// the histogram and cumulative memories.
// Frame start clears the histogram with a pass over all 256 bins, one bin a
// cycle, then counts the pixel.
// After reset a clearing pass runs; in_stall is high meanwhile.
// Results sit in an output register; while out_stall is high the block holds
// the result and takes no new item until it is transferred.
module histogram_equalizer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] pixel,
  input  logic       frame_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_pixel,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] levels
);
  localparam int unsigned CW = histeq_pkg::CNT_W;
  localparam int unsigned BW = histeq_pkg::BIN_W;

  histeq_pkg::state_t state;
  logic [histeq_pkg::LVL_W-1:0] levels_q;
  logic [CW-1:0] total;
  logic [CW-1:0] cdfmin;
  logic [CW-1:0] run;
  logic          found;
  logic          cum_ready;
  logic [BW:0]   idx;
  logic [BW-1:0] pix_q;
  logic          fs_q;
  logic          func_q;
  logic [CW-1:0] cval;
  logic [7:0]    res;
  logic          res_valid;

  logic          h_we;
  logic [BW-1:0] h_waddr;
  logic [CW-1:0] h_wdata;
  logic [BW-1:0] h_raddr;
  logic [CW-1:0] h_rdata;
  logic          c_we;
  logic [BW-1:0] c_waddr;
  logic [CW-1:0] c_wdata;
  logic [BW-1:0] c_raddr;
  logic [CW-1:0] c_rdata;
  logic [CW-1:0] run_next;

  histeq_pkg::div_req_t dreq;
  histeq_pkg::div_rsp_t drsp;

  histeq_ram #(.WIDTH(CW), .DEPTH(histeq_pkg::BINS)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata));

  histeq_ram #(.WIDTH(CW), .DEPTH(histeq_pkg::BINS)) u_cum (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata));

  histeq_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_stall  = (state != histeq_pkg::ST_IDLE) || res_valid;
  assign cfg_ready = 1'b1;
  assign out_valid = res_valid;
  assign out_pixel = res;
  assign run_next  = run + h_rdata;

  // memory port control
  always_comb begin
    h_we    = 1'b0;
    h_waddr = pix_q;
    h_wdata = h_rdata + 1'b1;
    h_raddr = pix_q;
    c_we    = 1'b0;
    c_waddr = idx[BW-1:0] - 1'b1;
    c_wdata = run_next;
    c_raddr = pix_q;
    case (state)
      histeq_pkg::ST_CLR: begin
        h_we    = 1'b1;
        h_waddr = idx[BW-1:0];
        h_wdata = '0;
      end
      histeq_pkg::ST_CNT_W: begin
        h_we = 1'b1;
      end
      histeq_pkg::ST_BUILD: begin
        h_raddr = idx[BW-1:0];
        c_we    = (idx != 0);
      end
      default: ;
    endcase
  end

  // divider request, issued from the cumulative read data
  always_comb begin
    dreq.start = (state == histeq_pkg::ST_MAP_D) && (total > cdfmin) && (c_rdata > cdfmin);
    dreq.num   = histeq_pkg::NUM_W'(levels_q) * histeq_pkg::NUM_W'(c_rdata - cdfmin);
    dreq.den   = total - cdfmin;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= histeq_pkg::ST_CLR;
      idx       <= '0;
      levels_q  <= histeq_pkg::LEVELS_RST;
      total     <= '0;
      cdfmin    <= '0;
      cum_ready <= 1'b0;
      res_valid <= 1'b0;
      func_q    <= histeq_pkg::FUNC_COUNT;
      fs_q      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        levels_q <= levels;
      end
      if (res_valid && !out_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        histeq_pkg::ST_IDLE: begin
          if (in_valid && !in_stall) begin
            pix_q  <= pixel;
            func_q <= func;
            fs_q   <= frame_start;
            if (func == histeq_pkg::FUNC_COUNT) begin
              cum_ready <= 1'b0;
              if (frame_start) begin
                total <= '0;
                idx   <= '0;
                state <= histeq_pkg::ST_CLR;
              end else if (total < histeq_pkg::MAX_PIXELS) begin
                state <= histeq_pkg::ST_CNT_R;
              end
            end else if (!cum_ready) begin
              idx    <= '0;
              run    <= '0;
              found  <= 1'b0;
              cdfmin <= '0;
              state  <= histeq_pkg::ST_BUILD;
            end else begin
              state <= histeq_pkg::ST_MAP_R;
            end
          end
        end
        histeq_pkg::ST_CLR: begin
          if (idx[BW-1:0] == '1) begin
            idx <= '0;
            // pending count after a frame start clear
            if (fs_q && func_q == histeq_pkg::FUNC_COUNT) begin
              fs_q  <= 1'b0;
              state <= histeq_pkg::ST_CNT_R;
            end else begin
              state <= histeq_pkg::ST_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        histeq_pkg::ST_CNT_R: state <= histeq_pkg::ST_CNT_W;
        histeq_pkg::ST_CNT_W: begin
          total <= total + 1'b1;
          state <= histeq_pkg::ST_IDLE;
        end
        histeq_pkg::ST_BUILD: begin
          // read bin idx, accumulate bin idx-1
          if (idx != 0) begin
            run <= run_next;
            if (!found && run_next != '0) begin
              found  <= 1'b1;
              cdfmin <= run_next;
            end
          end
          idx <= idx + 1'b1;
          if (idx[BW]) begin
            cum_ready <= 1'b1;
            state     <= histeq_pkg::ST_MAP_R;
          end
        end
        histeq_pkg::ST_MAP_R: state <= histeq_pkg::ST_MAP_D;
        histeq_pkg::ST_MAP_D: begin
          cval <= c_rdata;
          state <= histeq_pkg::ST_DIV;
        end
        histeq_pkg::ST_DIV: begin
          if (!((total > cdfmin) && (cval > cdfmin))) begin
            res   <= '0;
            state <= histeq_pkg::ST_OUT;
          end else if (drsp.done) begin
            res   <= (drsp.quo > 255) ? 8'd255 : drsp.quo[7:0];
            state <= histeq_pkg::ST_OUT;
          end
        end
        histeq_pkg::ST_OUT: begin
          res_valid <= 1'b1;
          state     <= histeq_pkg::ST_IDLE;
        end
        default: state <= histeq_pkg::ST_IDLE;
      endcase
    end
  end

  ap_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  ap_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (state == histeq_pkg::ST_IDLE && !res_valid))
    else $error("accepted while busy");
  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pixel)))
    else $error("result dropped");
  ap_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= histeq_pkg::MAX_PIXELS) else $error("total beyond max");
endmodule

/* dv/tb_histogram_equalizer_core.sv */
`timescale 1ns / 1ps
module tb_histogram_equalizer_core;
  typedef struct {
    logic                         func;
    logic [histeq_pkg::PIX_W-1:0] pixel;
    logic                         fs;
  } pix_item_t;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned SEG_ITEMS = 175;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             func = histeq_pkg::FUNC_COUNT;
  logic [7:0]       pixel = '0;
  logic             frame_start = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_pixel;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [7:0]       levels = histeq_pkg::LEVELS_RST;

  // stimulus and expected equalized pixels
  pix_item_t                    pending_q[$];
  logic [histeq_pkg::PIX_W-1:0] eq_pixel_q[$];
  int unsigned      n_errors = 0;
  int unsigned      cycle_cnt = 0;
  int unsigned      snd_idle_pct = 0;
  int unsigned      rcv_stall_pct = 0;

  // predictor state
  logic [histeq_pkg::CNT_W-1:0] hist_bins[histeq_pkg::BINS];
  logic [histeq_pkg::CNT_W-1:0] cdf_tab[histeq_pkg::BINS];
  logic [histeq_pkg::CNT_W-1:0] px_total;
  logic [histeq_pkg::CNT_W-1:0] cdf_min;
  logic                         cdf_valid;
  logic [histeq_pkg::LVL_W-1:0] lvl_model;

  histogram_equalizer_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pixel   (out_pixel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .levels      (levels)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // cumulative table and first nonzero cumulative count
  task automatic build_cdf();
    logic [histeq_pkg::CNT_W-1:0] run;
    bit                           found;
    run = '0;
    found = 0;
    cdf_min = '0;
    for (int i = 0; i < histeq_pkg::BINS; i++) begin
      run = run + hist_bins[i];
      cdf_tab[i] = run;
      if (!found && run != 0) begin
        cdf_min = run;
        found = 1;
      end
    end
    cdf_valid = 1'b1;
  endtask

  // update the histogram, or queue the equalized value of a map transfer
  task automatic equalize_predict(input pix_item_t it);
    logic [histeq_pkg::CNT_W-1:0] c;
    longint unsigned              quo;
    logic [histeq_pkg::PIX_W-1:0] res;
    if (it.func == histeq_pkg::FUNC_COUNT) begin
      if (it.fs) begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        px_total = '0;
      end
      cdf_valid = 1'b0;
      if (px_total < histeq_pkg::MAX_PIXELS) begin
        hist_bins[it.pixel] = hist_bins[it.pixel] + 1'b1;
        px_total = px_total + 1'b1;
      end
    end else begin
      if (!cdf_valid) build_cdf();
      c = cdf_tab[it.pixel];
      res = '0;
      if (px_total != cdf_min && c > cdf_min && px_total > cdf_min) begin
        quo = (longint'(lvl_model) * longint'(c - cdf_min)) / longint'(px_total - cdf_min);
        res = (quo > 255) ? 8'd255 : quo[7:0];
      end
      eq_pixel_q.push_back(res);
    end
  endtask

  // driver: hold payload while stalled, idle at random between transfers
  always @(posedge clk) begin
    pix_item_t nxt;
    pix_item_t cur;
    bit        fire;
    fire = in_valid && !in_stall;
    if (fire) begin
      cur.func = func;
      cur.pixel = pixel;
      cur.fs = frame_start;
      equalize_predict(cur);
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || fire) begin
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        nxt = pending_q.pop_front();
        in_valid <= 1'b1;
        func <= nxt.func;
        pixel <= nxt.pixel;
        frame_start <= nxt.fs;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    logic [histeq_pkg::PIX_W-1:0] exp_pix;
    if (!rst && out_valid && !out_stall) begin
      if (eq_pixel_q.size() == 0) begin
        $display("%0t: unexpected out_pixel %0d", $time, out_pixel);
        n_errors++;
      end else begin
        exp_pix = eq_pixel_q.pop_front();
        if (out_pixel !== exp_pix) begin
          $display("%0t: out_pixel mismatch, expected %0d, got %0d",
                   $time, exp_pix, out_pixel);
          n_errors++;
        end
      end
    end
    out_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_item(input logic f, input logic [7:0] p, input logic fs);
    pix_item_t it;
    it.func = f;
    it.pixel = p;
    it.fs = fs;
    pending_q.push_back(it);
  endtask

  task automatic write_levels(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    levels <= v;
    do @(posedge clk); while (!cfg_ready);
    lvl_model = v;
    cfg_valid <= 1'b0;
  endtask

  // block until all transfers are done, then let a frame clear finish
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_q.size() > 0 || in_valid || eq_pixel_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one frame: counts over a random span of grey values, then maps
  task automatic add_frame(inout int unsigned n_added);
    int unsigned n_cnt;
    int unsigned n_map;
    int unsigned spread;
    logic [7:0]  base;
    n_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 25);
    base = 8'($urandom);
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 3;
      2: spread = 40;
      default: spread = 255;
    endcase
    for (int i = 0; i < n_cnt; i++) begin
      push_item(histeq_pkg::FUNC_COUNT, base + 8'($urandom_range(0, spread)), i == 0);
      // occasional noise: a frame start in mid-frame or an early map
      if ($urandom_range(0, 29) == 0)
        push_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b1);
    end
    n_map = $urandom_range(1, 20);
    for (int i = 0; i < n_map; i++) begin
      if ($urandom_range(0, 2) == 0)
        push_item(histeq_pkg::FUNC_MAP, 8'($urandom), 1'($urandom_range(0, 1)));
      else
        push_item(histeq_pkg::FUNC_MAP, base + 8'($urandom_range(0, spread)),
                  1'($urandom_range(0, 1)));
      // a late count without frame start forces a rebuild
      if ($urandom_range(0, 24) == 0)
        push_item(histeq_pkg::FUNC_COUNT, 8'($urandom), 1'b0);
    end
    n_added += n_cnt + n_map;
  endtask

  initial begin
    int unsigned n_added;
    logic [7:0]  seg_lvl[6];
    foreach (hist_bins[i]) begin
      hist_bins[i] = '0;
      cdf_tab[i] = '0;
    end
    px_total = '0;
    cdf_min = '0;
    cdf_valid = 1'b0;
    lvl_model = histeq_pkg::LEVELS_RST;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_levels(8'd255);

    // directed: empty histogram, ignored frame start on a map
    push_item(histeq_pkg::FUNC_MAP, 8'd0, 1'b0);
    push_item(histeq_pkg::FUNC_MAP, 8'd255, 1'b1);
    // extremes of the pixel range
    push_item(histeq_pkg::FUNC_COUNT, 8'd0, 1'b1);
    push_item(histeq_pkg::FUNC_COUNT, 8'd255, 1'b0);
    push_item(histeq_pkg::FUNC_COUNT, 8'd255, 1'b0);
    push_item(histeq_pkg::FUNC_COUNT, 8'd128, 1'b0);
    push_item(histeq_pkg::FUNC_MAP, 8'd0, 1'b0);
    push_item(histeq_pkg::FUNC_MAP, 8'd255, 1'b0);
    push_item(histeq_pkg::FUNC_MAP, 8'd128, 1'b0);
    push_item(histeq_pkg::FUNC_MAP, 8'd127, 1'b0);
    // histogram changed by a count without frame start
    push_item(histeq_pkg::FUNC_COUNT, 8'd0, 1'b0);
    push_item(histeq_pkg::FUNC_MAP, 8'd128, 1'b0);
    // flat denominator: one grey value only
    push_item(histeq_pkg::FUNC_COUNT, 8'd7, 1'b1);
    push_item(histeq_pkg::FUNC_COUNT, 8'd7, 1'b0);
    push_item(histeq_pkg::FUNC_COUNT, 8'd7, 1'b0);
    push_item(histeq_pkg::FUNC_MAP, 8'd7, 1'b0);
    push_item(histeq_pkg::FUNC_MAP, 8'd200, 1'b0);
    // pixel below cdfmin
    push_item(histeq_pkg::FUNC_COUNT, 8'd100, 1'b1);
    push_item(histeq_pkg::FUNC_COUNT, 8'd200, 1'b0);
    push_item(histeq_pkg::FUNC_MAP, 8'd50, 1'b0);
    push_item(histeq_pkg::FUNC_MAP, 8'd200, 1'b0);
    push_item(histeq_pkg::FUNC_MAP, 8'd100, 1'b0);
    wait_idle();

    // random frames: two levels settings per idling mode
    seg_lvl[0] = 8'd255;
    seg_lvl[1] = 8'd0;
    seg_lvl[2] = 8'd1;
    seg_lvl[3] = 8'($urandom_range(2, 254));
    seg_lvl[4] = 8'd128;
    seg_lvl[5] = 8'($urandom_range(2, 254));
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          snd_idle_pct = 15;
          rcv_stall_pct = 83;
        end
        1: begin
          snd_idle_pct = 83;
          rcv_stall_pct = 15;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
        end
      endcase
      write_levels(seg_lvl[seg]);
      n_added = 0;
      while (n_added < SEG_ITEMS) add_frame(n_added);
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
